/* hdl/ustig_pkg.sv */
// Shared widths, register indexes and triangle types of the UV-sphere index generator.
package ustig_pkg;

  localparam int VERT_W     = 19;
  localparam int BASE_W     = 20;
  localparam int LON_CFG_W  = 11;
  localparam int LAT_CFG_W  = 10;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [LON_CFG_W-1:0] LON_RESET = LON_CFG_W'(360);
  localparam logic [LAT_CFG_W-1:0] LAT_RESET = LAT_CFG_W'(180);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LON_COUNT = 1'b0,
    REG_LAT_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [VERT_W-1:0] first_vertex;
    logic [VERT_W-1:0] second_vertex;
    logic [VERT_W-1:0] third_vertex;
    logic              last_of_step;
    logic              mesh_done;
  } tri_t;

  // Everything one request produces: one or two triangles.
  typedef struct packed {
    tri_t first_tri;
    tri_t second_tri;
    logic two;
  } pair_t;

endpackage

/* hdl/uv_sphere_triangle_index_generator_unit.sv */
// Top level of the UV-sphere triangle index generator.
// The block walks a latitude/longitude sphere mesh and emits vertex-index
// triangles. Each request on the in_ channel carries in_restart: 1 starts the
// mesh at band 0, column 0; 0 advances one column. A request gives one
// triangle in the polar caps and two in the middle bands, delivered one per
// transfer on the out_ channel with last_of_step on the final one and
// mesh_done on the very last triangle of the sphere.
// A request's triangles are registered in the result queue behind earlier ones.
// Requests are taken one per cycle while in_stall is low; the output gives one
// triangle per cycle without out_stall; middle-band requests are paced by the
// single triangle per output transfer. A two-entry result queue lets a new
// request enter while an earlier result waits; in_stall rises only when that
// queue is full, so a stalled receiver backs up to the input within two requests.
// lon_count and lat_count are written on the cfg_ port; the user must write them
// only while the block is idle, which it does not enforce. Reset sets them to 360
// and 180; until a restart, as after the mesh ends, requests give no triangles.
module uv_sphere_triangle_index_generator_unit import ustig_pkg::*; #(
  parameter int MAX_LON = 1024,
  parameter int MAX_LAT = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_restart,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VERT_W-1:0]     out_first_vertex,
  output logic [VERT_W-1:0]     out_second_vertex,
  output logic [VERT_W-1:0]     out_third_vertex,
  output logic                  out_last_of_step,
  output logic                  out_mesh_done
);

  logic [LON_CFG_W-1:0] lon_count_r, lon_count_nxt;
  logic [LAT_CFG_W-1:0] lat_count_r, lat_count_nxt;
  logic                 req_take;
  logic                 push;
  logic                 full;
  pair_t                pair;
  tri_t                 out_tri;

  always_comb begin
    lon_count_nxt = lon_count_r;
    lat_count_nxt = lat_count_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LON_COUNT: lon_count_nxt = cfg_wdata[LON_CFG_W-1:0];
        REG_LAT_COUNT: lat_count_nxt = cfg_wdata[LAT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_count_r <= LON_RESET;
      lat_count_r <= LAT_RESET;
    end else begin
      lon_count_r <= lon_count_nxt;
      lat_count_r <= lat_count_nxt;
    end
  end

  assign in_stall = full;
  assign req_take = in_valid && !full;

  ustig_seq #(
    .MAX_LON(MAX_LON),
    .MAX_LAT(MAX_LAT)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .lon_count  (lon_count_r),
    .lat_count  (lat_count_r),
    .req_take   (req_take),
    .req_restart(in_restart),
    .push       (push),
    .pair       (pair)
  );

  ustig_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pair_in  (pair),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_tri  (out_tri)
  );

  assign out_first_vertex  = out_tri.first_vertex;
  assign out_second_vertex = out_tri.second_vertex;
  assign out_third_vertex  = out_tri.third_vertex;
  assign out_last_of_step  = out_tri.last_of_step;
  assign out_mesh_done     = out_tri.mesh_done;

endmodule

/* hdl/ustig_seq.sv */
// Mesh position sequencer: band/column counters, ring bases and triangle formation.
module ustig_seq import ustig_pkg::*; #(
  parameter int MAX_LON = 1024,
  parameter int MAX_LAT = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [LON_CFG_W-1:0] lon_count,
  input  logic [LAT_CFG_W-1:0] lat_count,
  input  logic                 req_take,
  input  logic                 req_restart,
  output logic                 push,
  output pair_t                pair
);

  localparam int COL_W  = $clog2(MAX_LON);
  localparam int BAND_W = $clog2(MAX_LAT);
  localparam int LON_NW = $clog2(MAX_LON + 1);
  localparam int LAT_NW = $clog2(MAX_LAT + 1);
  localparam int LON_VW = (LON_NW > LON_CFG_W) ? LON_NW : LON_CFG_W;
  localparam int LAT_VW = (LAT_NW > LAT_CFG_W) ? LAT_NW : LAT_CFG_W;

  localparam logic [LON_VW-1:0] LON_MIN = LON_VW'(3);
  localparam logic [LON_VW-1:0] LON_MAX = LON_VW'(MAX_LON);
  localparam logic [LAT_VW-1:0] LAT_MIN = LAT_VW'(2);
  localparam logic [LAT_VW-1:0] LAT_MAX = LAT_VW'(MAX_LAT);

  logic [BAND_W-1:0] band_r, band_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [BASE_W-1:0] up_base_r, up_base_nxt;
  logic [BASE_W-1:0] lo_base_r, lo_base_nxt;
  logic              finished_r, finished_nxt;

  logic [LON_VW-1:0] lon_raw, eff_lon, col_inc;
  logic [LAT_VW-1:0] lat_raw, eff_lat, band_inc;
  logic [BAND_W-1:0] band_cur;
  logic [COL_W-1:0]  col_cur;
  logic [BASE_W-1:0] up_cur, lo_cur, up_l, up_rgt, lo_l, lo_rgt, lon_ext;
  logic              last_col, last_band;

  // Registers are read live and clamped to the supported range.
  always_comb begin
    lon_raw = LON_VW'(lon_count);
    lat_raw = LAT_VW'(lat_count);
    if (lon_raw < LON_MIN) begin
      eff_lon = LON_MIN;
    end else if (lon_raw > LON_MAX) begin
      eff_lon = LON_MAX;
    end else begin
      eff_lon = lon_raw;
    end
    if (lat_raw < LAT_MIN) begin
      eff_lat = LAT_MIN;
    end else if (lat_raw > LAT_MAX) begin
      eff_lat = LAT_MAX;
    end else begin
      eff_lat = lat_raw;
    end
  end

  always_comb begin
    // A restart request works on the first position directly.
    band_cur = req_restart ? '0 : band_r;
    col_cur  = req_restart ? '0 : col_r;
    up_cur   = req_restart ? '0 : up_base_r;
    lo_cur   = req_restart ? BASE_W'(1) : lo_base_r;

    col_inc   = LON_VW'(col_cur) + LON_VW'(1);
    band_inc  = LAT_VW'(band_cur) + LAT_VW'(1);
    last_col  = (col_inc >= eff_lon);
    last_band = (band_inc >= eff_lat);
    lon_ext   = BASE_W'(eff_lon);

    up_l   = up_cur + BASE_W'(col_cur);
    lo_l   = lo_cur + BASE_W'(col_cur);
    up_rgt = last_col ? up_cur : up_l + BASE_W'(1);
    lo_rgt = last_col ? lo_cur : lo_l + BASE_W'(1);

    push = req_take && (req_restart || !finished_r);

    pair = '0;
    if (band_cur == '0) begin
      pair.first_tri.first_vertex  = '0;
      pair.first_tri.second_vertex = lo_l[VERT_W-1:0];
      pair.first_tri.third_vertex  = lo_rgt[VERT_W-1:0];
      pair.first_tri.last_of_step  = 1'b1;
      pair.first_tri.mesh_done     = last_col && last_band;
    end else if (last_band) begin
      pair.first_tri.first_vertex  = lo_cur[VERT_W-1:0];
      pair.first_tri.second_vertex = up_l[VERT_W-1:0];
      pair.first_tri.third_vertex  = up_rgt[VERT_W-1:0];
      pair.first_tri.last_of_step  = 1'b1;
      pair.first_tri.mesh_done     = last_col;
    end else begin
      pair.two                      = 1'b1;
      pair.first_tri.first_vertex   = up_l[VERT_W-1:0];
      pair.first_tri.second_vertex  = lo_l[VERT_W-1:0];
      pair.first_tri.third_vertex   = lo_rgt[VERT_W-1:0];
      pair.second_tri.first_vertex  = up_l[VERT_W-1:0];
      pair.second_tri.second_vertex = lo_rgt[VERT_W-1:0];
      pair.second_tri.third_vertex  = up_rgt[VERT_W-1:0];
      pair.second_tri.last_of_step  = 1'b1;
    end

    band_nxt     = band_r;
    col_nxt      = col_r;
    up_base_nxt  = up_base_r;
    lo_base_nxt  = lo_base_r;
    finished_nxt = finished_r;
    if (push) begin
      band_nxt     = band_cur;
      up_base_nxt  = up_cur;
      lo_base_nxt  = lo_cur;
      finished_nxt = 1'b0;
      if (last_col) begin
        col_nxt = '0;
        if (last_band) begin
          finished_nxt = 1'b1;
        end else begin
          up_base_nxt = (band_cur == '0) ? BASE_W'(1) : up_cur + lon_ext;
          lo_base_nxt = lo_cur + lon_ext;
          band_nxt    = band_inc[BAND_W-1:0];
        end
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r     <= '0;
      col_r      <= '0;
      up_base_r  <= '0;
      lo_base_r  <= BASE_W'(1);
      finished_r <= 1'b1;
    end else begin
      band_r     <= band_nxt;
      col_r      <= col_nxt;
      up_base_r  <= up_base_nxt;
      lo_base_r  <= lo_base_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

/* hdl/ustig_out.sv */
// Two-entry result queue that hands out the triangles of each request one at a time.
module ustig_out import ustig_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  pair_t pair_in,
  output logic  full,
  output logic  out_valid,
  input  logic  out_stall,
  output tri_t  out_tri
);

  pair_t       entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        sub_r, sub_nxt;
  pair_t       head;
  logic        pop_tri, pop_entry;

  always_comb begin
    head      = entry_r[rd_ptr_r];
    out_valid = (count_r != 2'd0);
    full      = (count_r == 2'd2);
    out_tri   = sub_r ? head.second_tri : head.first_tri;
    pop_tri   = out_valid && !out_stall;
    pop_entry = pop_tri && (sub_r || !head.two);

    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_entry ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop_entry};
    if (pop_entry) begin
      sub_nxt = 1'b0;
    end else if (pop_tri) begin
      sub_nxt = 1'b1;
    end else begin
      sub_nxt = sub_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= pair_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      sub_r    <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      sub_r    <= sub_nxt;
    end
  end

endmodule

/* tb/tb_uv_sphere_triangle_index_generator.sv */
// Self-checking testbench for the UV-sphere triangle index generator.
`timescale 1ns / 1ps

module tb;
  import ustig_pkg::*;

  localparam int MAX_LON         = 1024;
  localparam int MAX_LAT         = 512;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RANDOM_REQUESTS = 1050;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_restart;
  logic                  out_valid;
  logic                  out_stall;
  logic [VERT_W-1:0]     out_first_vertex;
  logic [VERT_W-1:0]     out_second_vertex;
  logic [VERT_W-1:0]     out_third_vertex;
  logic                  out_last_of_step;
  logic                  out_mesh_done;

  // Mirror of the register contents and of the walk position over the sphere.
  logic [LON_CFG_W-1:0] lon_setting;
  logic [LAT_CFG_W-1:0] lat_setting;
  logic [8:0]           band_pos;
  logic [9:0]           column_pos;
  logic [BASE_W-1:0]    upper_base;
  logic [BASE_W-1:0]    lower_base;
  logic                 walk_finished;

  tri_t awaited_triangles[$];
  int   mismatches = 0;
  int   mesh_requests = 0;
  int   in_calm = 0;
  int   out_calm = 0;
  int   stall_left = 0;

  uv_sphere_triangle_index_generator_unit uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 85) return $urandom_range(1, 3);
    else if (roll < 97) return $urandom_range(4, 12);
    else return $urandom_range(13, 40);
  endfunction

  function automatic int unsigned clamp_count(input int unsigned v, lo, hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic tri_t make_tri(input int unsigned a, b, c);
    tri_t t;
    t.first_vertex  = VERT_W'(a);
    t.second_vertex = VERT_W'(b);
    t.third_vertex  = VERT_W'(c);
    t.last_of_step  = 1'b0;
    t.mesh_done     = 1'b0;
    return t;
  endfunction

  // Advances the mirrored walk by one request and queues the triangles it yields.
  function automatic int predict_triangles(input logic restart);
    int unsigned lon_eff, lat_eff, col, up_l, up_r, lo_l, lo_r;
    bit          last_col, last_band;
    tri_t        tris[2];
    int          n;
    lon_eff = clamp_count(lon_setting, 3, MAX_LON);
    lat_eff = clamp_count(lat_setting, 2, MAX_LAT);
    if (restart) begin
      band_pos      = '0;
      column_pos    = '0;
      upper_base    = '0;
      lower_base    = BASE_W'(1);
      walk_finished = 1'b0;
    end else if (walk_finished) begin
      return 0;
    end
    col       = column_pos;
    last_col  = (col + 1 >= lon_eff);
    last_band = (band_pos + 1 >= lat_eff);
    up_l = upper_base + col;
    up_r = last_col ? upper_base : up_l + 1;
    lo_l = lower_base + col;
    lo_r = last_col ? lower_base : lo_l + 1;
    if (band_pos == 0) begin
      tris[0] = make_tri(0, lo_l, lo_r);
      n = 1;
    end else if (last_band) begin
      // South cap: the pole sits right after the last ring.
      tris[0] = make_tri(lower_base, up_l, up_r);
      n = 1;
    end else begin
      tris[0] = make_tri(up_l, lo_l, lo_r);
      tris[1] = make_tri(up_l, lo_r, up_r);
      n = 2;
    end
    tris[n-1].last_of_step = 1'b1;
    if (last_col) begin
      column_pos = '0;
      if (last_band) begin
        walk_finished = 1'b1;
        tris[n-1].mesh_done = 1'b1;
      end else begin
        upper_base = (band_pos == 0) ? BASE_W'(1) : BASE_W'(upper_base + lon_eff);
        lower_base = BASE_W'(lower_base + lon_eff);
        band_pos   = band_pos + 1'b1;
      end
    end else begin
      column_pos = column_pos + 1'b1;
    end
    for (int k = 0; k < n; k++) awaited_triangles.push_back(tris[k]);
    return n;
  endfunction

  // Leaves in_valid high after acceptance so that back-to-back requests need no dip.
  task automatic send_request(input logic restart);
    int gap;
    if (in_calm > 0) begin
      in_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) in_calm = $urandom_range(20, 80);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_triangles(restart) > 0) mesh_requests++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_triangles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned lon, input int unsigned lat);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_LON_COUNT;
    cfg_wdata <= CFG_DATA_W'(lon);
    @(posedge clk);
    cfg_index <= REG_LAT_COUNT;
    cfg_wdata <= CFG_DATA_W'(lat);
    @(posedge clk);
    cfg_we <= 1'b0;
    lon_setting = LON_CFG_W'(lon);
    lat_setting = LAT_CFG_W'(lat);
  endtask

  // After reset the block waits for a restart; plain steps give nothing.
  task automatic test_idle_after_reset();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
  endtask

  task automatic test_smallest_mesh();
    set_config(3, 2);
    send_request(1'b1);
    repeat (5) send_request(1'b0);
    send_request(1'b0);
  endtask

  task automatic test_middle_band();
    set_config(3, 3);
    send_request(1'b1);
    repeat (8) send_request(1'b0);
  endtask

  // Largest legal sizes, values beyond range, and shrinking the mesh mid-walk.
  task automatic test_extreme_settings();
    set_config(MAX_LON, MAX_LAT);
    send_request(1'b1);
    send_request(1'b0);
    set_config(2047, 1023);
    send_request(1'b0);
    set_config(0, 0);
    send_request(1'b0);
    send_request(1'b0);
  endtask

  task automatic test_random_meshes();
    int unsigned lon, lat, mesh_size, steps, roll;
    int          target;
    bit          do_restart;
    target = mesh_requests + RANDOM_REQUESTS;
    while (mesh_requests < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        lon = $urandom_range(3, 8);
        lat = $urandom_range(2, 6);
      end else if (roll < 80) begin
        lon = $urandom_range(0, 2);
        lat = $urandom_range(0, 1);
      end else if (roll < 90) begin
        lon = $urandom_range(9, 40);
        lat = $urandom_range(2, 4);
      end else if (roll < 95) begin
        lon = $urandom_range(3, 6);
        lat = $urandom_range(7, 12);
      end else begin
        lon = $urandom_range(1025, 2047);
        lat = $urandom_range(513, 1023);
      end
      // Settings are kept now and then; skipping the restart lets a walk continue, at times under new ones.
      if ($urandom_range(0, 3) != 0) set_config(lon, lat);
      mesh_size = clamp_count(lon_setting, 3, MAX_LON) * clamp_count(lat_setting, 2, MAX_LAT);
      if (mesh_size > 200) steps = $urandom_range(1, 30);
      else if ($urandom_range(0, 3) != 0) steps = mesh_size + $urandom_range(0, 2);
      else steps = $urandom_range(1, mesh_size);
      do_restart = ($urandom_range(0, 99) < 85);
      for (int unsigned i = 0; i < steps; i++)
        send_request((i == 0 && do_restart) || ($urandom_range(0, 199) == 0));
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_calm > 0) out_calm--;
      else if ($urandom_range(0, 59) == 0) out_calm = $urandom_range(20, 80);
      else stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    tri_t got;
    tri_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.first_vertex  = out_first_vertex;
      got.second_vertex = out_second_vertex;
      got.third_vertex  = out_third_vertex;
      got.last_of_step  = out_last_of_step;
      got.mesh_done     = out_mesh_done;
      if (awaited_triangles.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected triangle (%0d, %0d, %0d) last=%0b done=%0b",
                   got.first_vertex, got.second_vertex, got.third_vertex,
                   got.last_of_step, got.mesh_done);
        mismatches++;
      end else begin
        want = awaited_triangles.pop_front();
        if (got.first_vertex !== want.first_vertex ||
            got.second_vertex !== want.second_vertex ||
            got.third_vertex !== want.third_vertex ||
            got.last_of_step !== want.last_of_step ||
            got.mesh_done !== want.mesh_done) begin
          if (mismatches < 10)
            $display("mismatch: expected (%0d, %0d, %0d) last=%0b done=%0b, got (%0d, %0d, %0d) last=%0b done=%0b",
                     want.first_vertex, want.second_vertex, want.third_vertex,
                     want.last_of_step, want.mesh_done,
                     got.first_vertex, got.second_vertex, got.third_vertex,
                     got.last_of_step, got.mesh_done);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_LON_COUNT;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_restart <= 1'b0;
    out_stall  <= 1'b0;
    lon_setting   = LON_RESET;
    lat_setting   = LAT_RESET;
    band_pos      = '0;
    column_pos    = '0;
    upper_base    = '0;
    lower_base    = BASE_W'(1);
    walk_finished = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_after_reset();
    test_smallest_mesh();
    test_middle_band();
    test_extreme_settings();
    test_random_meshes();
    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ustig_pkg.sv
hdl/ustig_seq.sv
hdl/ustig_out.sv
hdl/uv_sphere_triangle_index_generator_unit.sv
tb/tb_uv_sphere_triangle_index_generator.sv
